### rtl/fcar_pkg.sv
// ----------------------------------------------------------------------------
// fcar_pkg: shared types and constants of the frame checksum address router
// Register codes, back-end states and the command and done records that
// pass between the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package fcar_pkg;

  localparam int unsigned HeaderBytes = 4;
  localparam int unsigned HopIndex    = 3;

  localparam logic [7:0] MasterAddr    = 8'h00;
  localparam logic [7:0] SumGood       = 8'hFF;
  localparam logic [7:0] OwnAddrReset  = 8'd37;
  localparam logic [7:0] ProtoVerReset = 8'd6;
  localparam logic [7:0] FillByte      = 8'h00;

  typedef enum logic {
    CFG_OWN_ADDR  = 1'b0,
    CFG_PROTO_VER = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_LOAD
  } bk_state_e;

  typedef struct packed {
    logic       fwd;
    logic       bank;
    logic [7:0] chk;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

endpackage

### rtl/fcar_if.sv
// ----------------------------------------------------------------------------
// fcar_if: word channels of the frame checksum address router
// Input byte channel and output result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fcar_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface fcar_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data;
  logic       last;

  modport source (output valid, output kind, output data, output last, input ready);
  modport sink (input valid, input kind, input data, input last, output ready);
endinterface

### rtl/fcar_front.sv
// ----------------------------------------------------------------------------
// fcar_front: frame tracker and classifier
// Counts byte positions, writes the network unit into the store bank of
// the current frame, sums the checksum and judges the frame at its trailer.
// ----------------------------------------------------------------------------
module fcar_front #(
  parameter int unsigned PAYLOAD_BYTES = 9,
  localparam int unsigned UnitLen  = fcar_pkg::HeaderBytes + PAYLOAD_BYTES,
  localparam int unsigned FrameLen = UnitLen + 3,
  localparam int unsigned PosW     = $clog2(FrameLen),
  localparam int unsigned AddrW    = $clog2(2 * UnitLen)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  fcar_in_if.sink            in_if,
  input  logic [7:0]         own_addr_i,
  input  logic [7:0]         proto_ver_i,
  output logic               wr_en_o,
  output logic [AddrW-1:0]   wr_addr_o,
  output logic [7:0]         wr_data_o,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output fcar_pkg::cmd_t     cmd_o,
  input  fcar_pkg::done_t    done_i
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      to_q, from_q, ver_q, chk_q;
  logic            bank_q, bank_d;
  logic [1:0]      busy_q, busy_d;
  logic            accept;
  logic            in_unit, at_chk, at_trailer, frame_ok;
  logic [PosW-1:0] off;
  logic [PosW:0]   addr_full;

  assign in_if.ready = !busy_q[bank_q] && cmd_ready_i;
  assign accept      = in_if.valid && in_if.ready;

  assign in_unit    = (pos_q != '0) && (pos_q <= PosW'(UnitLen));
  assign at_chk     = pos_q == PosW'(UnitLen + 1);
  assign at_trailer = pos_q == PosW'(FrameLen - 1);

  assign off       = pos_q - PosW'(1);
  assign addr_full = bank_q ? ((PosW + 1)'(UnitLen) + {1'b0, off}) : {1'b0, off};

  assign wr_en_o   = accept && in_unit;
  assign wr_addr_o = addr_full[AddrW-1:0];
  assign wr_data_o = in_if.byte_in;

  assign frame_ok = (sum_q == fcar_pkg::SumGood) && (ver_q == proto_ver_i)
                 && (from_q == fcar_pkg::MasterAddr) && (to_q != fcar_pkg::MasterAddr);

  assign cmd_valid_o = accept && at_trailer && frame_ok;
  assign cmd_o.fwd   = to_q != own_addr_i;
  assign cmd_o.bank  = bank_q;
  assign cmd_o.chk   = chk_q - 8'd1;

  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    bank_d = bank_q;
    busy_d = busy_q;
    if (accept) begin
      if (at_trailer) begin
        pos_d  = '0;
        bank_d = !bank_q;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
      if (pos_q == '0) begin
        sum_d = '0;
      end else if (in_unit || at_chk) begin
        sum_d = sum_q + in_if.byte_in;
      end
    end
    if (done_i.valid) begin
      busy_d[done_i.bank] = 1'b0;
    end
    if (cmd_valid_o) begin
      busy_d[bank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      bank_q <= 1'b0;
      busy_q <= '0;
    end else begin
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (pos_q == PosW'(1)) to_q <= in_if.byte_in;
      if (pos_q == PosW'(2)) from_q <= in_if.byte_in;
      if (pos_q == PosW'(3)) ver_q <= in_if.byte_in;
      if (at_chk) chk_q <= in_if.byte_in;
    end
  end

endmodule

### rtl/fcar_queue.sv
// ----------------------------------------------------------------------------
// fcar_queue: two-entry command queue
// Holds judged frames between the front end and the back end.
// ----------------------------------------------------------------------------
module fcar_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  fcar_pkg::cmd_t  push_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output fcar_pkg::cmd_t  pop_o
);

  fcar_pkg::cmd_t ent_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_o        = ent_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop) rptr_q <= !rptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wptr_q] <= push_i;
  end

endmodule

### rtl/fcar_back.sv
// ----------------------------------------------------------------------------
// fcar_back: frame store and result emitter
// Two-bank frame store; drains a judged bank as payload words or as a
// rebuilt frame through a registered output.
// ----------------------------------------------------------------------------
module fcar_back #(
  parameter int unsigned PAYLOAD_BYTES = 9,
  localparam int unsigned UnitLen = fcar_pkg::HeaderBytes + PAYLOAD_BYTES,
  localparam int unsigned IdxW    = $clog2(UnitLen + 3),
  localparam int unsigned AddrW   = $clog2(2 * UnitLen)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  fcar_pkg::cmd_t     cmd_i,
  input  logic               wr_en_i,
  input  logic [AddrW-1:0]   wr_addr_i,
  input  logic [7:0]         wr_data_i,
  fcar_out_if.source         out_if,
  output fcar_pkg::done_t    done_o
);

  fcar_pkg::bk_state_e state_q, state_d;
  fcar_pkg::cmd_t      cmd_q;
  logic [7:0]          mem_q [2 * UnitLen];
  logic [7:0]          rdata_q;
  logic [IdxW-1:0]     idx_q;
  logic                out_valid_q;
  logic                out_kind_q, out_last_q;
  logic [7:0]          out_data_q;
  logic                rd_en, load, load_ok, take_cmd;
  logic [IdxW-1:0]     off;
  logic [IdxW:0]       addr_full;
  logic [AddrW-1:0]    rd_addr;
  logic [7:0]          byte_sel;
  logic                byte_last;

  assign load_ok = !out_valid_q || out_if.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      fcar_pkg::BK_IDLE: begin
        if (cmd_valid_i) state_d = fcar_pkg::BK_FETCH;
      end
      fcar_pkg::BK_FETCH: begin
        state_d = fcar_pkg::BK_LOAD;
      end
      fcar_pkg::BK_LOAD: begin
        if (load_ok) state_d = byte_last ? fcar_pkg::BK_IDLE : fcar_pkg::BK_FETCH;
      end
      default: begin
        state_d = fcar_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_ready_o = 1'b0;
    rd_en       = 1'b0;
    load        = 1'b0;
    case (state_q)
      fcar_pkg::BK_IDLE:  cmd_ready_o = 1'b1;
      fcar_pkg::BK_FETCH: rd_en = 1'b1;
      fcar_pkg::BK_LOAD:  load = load_ok;
      default: begin
        cmd_ready_o = 1'b0;
      end
    endcase
  end

  assign take_cmd = cmd_ready_o && cmd_valid_i;

  assign off       = cmd_q.fwd ? (idx_q - IdxW'(1)) : (idx_q + IdxW'(fcar_pkg::HeaderBytes));
  assign addr_full = cmd_q.bank ? ((IdxW + 1)'(UnitLen) + {1'b0, off}) : {1'b0, off};
  assign rd_addr   = addr_full[AddrW-1:0];

  always_comb begin
    byte_sel  = rdata_q;
    byte_last = 1'b0;
    if (!cmd_q.fwd) begin
      byte_last = idx_q == IdxW'(PAYLOAD_BYTES - 1);
    end else if (idx_q == '0) begin
      byte_sel = fcar_pkg::FillByte;
    end else if (idx_q <= IdxW'(UnitLen)) begin
      byte_sel = (idx_q == IdxW'(fcar_pkg::HopIndex + 1)) ? rdata_q + 8'd1 : rdata_q;
    end else if (idx_q == IdxW'(UnitLen + 1)) begin
      byte_sel = cmd_q.chk;
    end else begin
      byte_sel  = fcar_pkg::FillByte;
      byte_last = 1'b1;
    end
  end

  assign done_o.valid = load && byte_last;
  assign done_o.bank  = cmd_q.bank;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fcar_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q <= state_d;
      if (take_cmd) begin
        idx_q <= '0;
      end else if (load) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_cmd) cmd_q <= cmd_i;
    if (load) begin
      out_kind_q <= cmd_q.fwd;
      out_data_q <= byte_sel;
      out_last_q <= byte_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  assign out_if.valid = out_valid_q;
  assign out_if.kind  = out_kind_q;
  assign out_if.data  = out_data_q;
  assign out_if.last  = out_last_q;

endmodule

### rtl/frame_checksum_address_router.sv
// ----------------------------------------------------------------------------
// frame_checksum_address_router: checksum-checked frame delivery and relay
// Judges fixed-length frames and emits payload words or rebuilt frames.
// ----------------------------------------------------------------------------
//   channel  dir  word                  handshake
//   in_if    in   byte_in[7:0]          valid/ready
//   out_if   out  kind, data[7:0], last valid/ready
//   apb      in   own_address @0x0, protocol_version @0x4, 8-bit each
//
// Input takes one word a cycle; it stalls only while the store bank of the
// incoming frame is still being drained or the command queue is full.
// Each output word passes through a registered store read, then the
// output register load. A frame yields PAYLOAD_BYTES or PAYLOAD_BYTES + 7.
// Reset clears control state and the config registers; the frame store and data registers are not cleared.
// ----------------------------------------------------------------------------
module frame_checksum_address_router #(
  parameter int unsigned PAYLOAD_BYTES = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fcar_in_if.sink     in_if,
  fcar_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned UnitLen = fcar_pkg::HeaderBytes + PAYLOAD_BYTES;
  localparam int unsigned AddrW   = $clog2(2 * UnitLen);

  logic [7:0]       own_addr_q, proto_ver_q;
  logic             cfg_wr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             cmd_push, q_ready, q_valid, q_pop_ready;
  fcar_pkg::cmd_t   cmd_in, cmd_out;
  fcar_pkg::done_t  done;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q  <= fcar_pkg::OwnAddrReset;
      proto_ver_q <= fcar_pkg::ProtoVerReset;
    end else if (cfg_wr) begin
      case (fcar_pkg::cfg_reg_e'(paddr[2]))
        fcar_pkg::CFG_OWN_ADDR:  own_addr_q <= pwdata[7:0];
        fcar_pkg::CFG_PROTO_VER: proto_ver_q <= pwdata[7:0];
        default: begin
          own_addr_q <= own_addr_q;
        end
      endcase
    end
  end

  always_comb begin
    case (fcar_pkg::cfg_reg_e'(paddr[2]))
      fcar_pkg::CFG_OWN_ADDR:  prdata = {24'd0, own_addr_q};
      fcar_pkg::CFG_PROTO_VER: prdata = {24'd0, proto_ver_q};
      default:                 prdata = '0;
    endcase
  end

  fcar_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .own_addr_i  (own_addr_q),
    .proto_ver_i (proto_ver_q),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .cmd_valid_o (cmd_push),
    .cmd_ready_i (q_ready),
    .cmd_o       (cmd_in),
    .done_i      (done)
  );

  fcar_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_push),
    .push_ready_o (q_ready),
    .push_i       (cmd_in),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_o        (cmd_out)
  );

  fcar_back #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_pop_ready),
    .cmd_i       (cmd_out),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .out_if      (out_if),
    .done_o      (done)
  );

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> q_ready)
    else $error("command pushed into a full queue");

  a_accept_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |-> q_ready)
    else $error("word accepted without queue room");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done.valid |=> (out_if.valid && out_if.last))
    else $error("bank released without a last word on the output");
`endif

endmodule
